// ----- design/gsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and constants for the gamepad sample conditioner
// Payload structs, controller commands, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    // fixed field widths
    localparam int AXIS_W     = 16;
    localparam int BTN_W      = 16;
    localparam int TRIG_W     = 8;
    localparam int DZ_W       = 15;
    localparam int ROOT_W     = 16;
    localparam int QUO_W      = 16;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 31;

    // full scale of a conditioned axis
    localparam logic [DZ_W-1:0] FULL_SCALE = 15'h7FFF;

    // dead zone reset values
    localparam logic [DZ_W-1:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [DZ_W-1:0] RIGHT_DZ_RESET = 15'd8689;

    // iteration counts of the shared root and divide steps
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_W     = 4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DZ  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DZ = 1'b1;

    // one poll sample
    typedef struct packed {
        logic                     poll_ok;
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] left_x;
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] right_x;
        logic signed [AXIS_W-1:0] right_y;
        logic [TRIG_W-1:0]        left_trigger;
        logic [TRIG_W-1:0]        right_trigger;
    } gsc_in_t;

    // one conditioned result
    typedef struct packed {
        logic [BTN_W-1:0]         pressed_mask;
        logic [BTN_W-1:0]         released_mask;
        logic [BTN_W-1:0]         held_mask;
        logic signed [AXIS_W-1:0] left_out_x;
        logic signed [AXIS_W-1:0] left_out_y;
        logic signed [AXIS_W-1:0] right_out_x;
        logic signed [AXIS_W-1:0] right_out_y;
        logic [2*TRIG_W-1:0]      left_trigger_level;
        logic [2*TRIG_W-1:0]      right_trigger_level;
    } gsc_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic square;
        logic root_init;
        logic root_step;
        logic prep;
        logic div_init;
        logic div_step;
        logic div_store;
        logic axis_y;
        logic load_out;
    } gsc_cmd_t;

endpackage

`default_nettype wire

// ----- design/gsc_stick.sv -----
// ----------------------------------------------------------------------------
// gsc_stick: one analog stick lane
// Squares, takes the integer root a bit per cycle, applies the radial dead
// zone and divides each axis a quotient bit per cycle with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_stick
    import gsc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire gsc_cmd_t                 cmd,
    input  wire logic signed [AXIS_W-1:0] raw_x,
    input  wire logic signed [AXIS_W-1:0] raw_y,
    input  wire logic [DZ_W-1:0]          deadzone,
    output logic signed [AXIS_W-1:0]      out_x,
    output logic signed [AXIS_W-1:0]      out_y
);

    logic signed [AXIS_W-1:0] x_reg, y_reg;
    logic [SQ_W-2:0]          xx_reg, yy_reg;
    logic [SQ_W-1:0]          rad_reg;
    logic [ROOT_W:0]          rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic                     zero_reg;
    logic [PROD_W-1:0]        div_reg, anx_reg, any_reg;
    logic [SQ_W-1:0]          prem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic signed [AXIS_W-1:0] out_x_reg, out_y_reg;

    logic [ROOT_W+2:0]        rem_shift, trial;
    logic                     root_ge;
    logic [DZ_W-1:0]          mag_clip, num, den;
    logic                     in_zone;
    logic [AXIS_W-1:0]        abs_x, abs_y;
    logic [PROD_W-1:0]        an_sel;
    logic [47:0]              dividend;
    logic [SQ_W-1:0]          divisor;
    logic [SQ_W:0]            part, part_diff;
    logic                     div_ge;
    logic [DZ_W-1:0]          q_sat;
    logic                     neg;
    logic signed [AXIS_W-1:0] axis_val;

    // root step: bring down two radicand bits, try root*4+1
    assign rem_shift = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_ge   = rem_shift >= trial;

    // dead zone terms
    assign in_zone  = ({1'b0, deadzone} >= root_reg) || (deadzone == FULL_SCALE);
    assign mag_clip = root_reg[ROOT_W-1] ? FULL_SCALE : root_reg[DZ_W-1:0];
    assign num      = mag_clip - deadzone;
    assign den      = FULL_SCALE - deadzone;
    assign abs_x    = x_reg[AXIS_W-1] ? (~x_reg + 16'd1) : x_reg;
    assign abs_y    = y_reg[AXIS_W-1] ? (~y_reg + 16'd1) : y_reg;

    // rounded divide: (a*num*2^16 + div) / (2*div), quotient fits 16 bits
    assign an_sel    = cmd.axis_y ? any_reg : anx_reg;
    assign dividend  = {1'b0, an_sel, 16'b0} + {17'b0, div_reg};
    assign divisor   = {div_reg, 1'b0};
    assign part      = {prem_reg, quo_reg[QUO_W-1]};
    assign div_ge    = part >= {1'b0, divisor};
    assign part_diff = part - {1'b0, divisor};

    // saturate and apply sign
    assign q_sat    = quo_reg[QUO_W-1] ? FULL_SCALE : quo_reg[DZ_W-1:0];
    assign neg      = cmd.axis_y ? y_reg[AXIS_W-1] : x_reg[AXIS_W-1];
    assign axis_val = zero_reg ? 16'sd0 :
                      (neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat}));

    // lane registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= raw_x;
            y_reg <= raw_y;
        end
        if (cmd.square) begin
            xx_reg <= 31'(x_reg * x_reg);
            yy_reg <= 31'(y_reg * y_reg);
        end
        if (cmd.root_init) begin
            rad_reg  <= {1'b0, xx_reg} + {1'b0, yy_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= root_ge ? 17'(rem_shift - trial) : 17'(rem_shift);
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
        end
        if (cmd.prep) begin
            zero_reg <= in_zone;
            div_reg  <= 31'(root_reg) * 31'(den);
            anx_reg  <= 31'(abs_x) * 31'(num);
            any_reg  <= 31'(abs_y) * 31'(num);
        end
        if (cmd.div_init) begin
            prem_reg <= dividend[47:16];
            quo_reg  <= dividend[15:0];
        end else if (cmd.div_step) begin
            prem_reg <= div_ge ? part_diff[SQ_W-1:0] : part[SQ_W-1:0];
            quo_reg  <= {quo_reg[QUO_W-2:0], div_ge};
        end
        if (cmd.div_store) begin
            if (cmd.axis_y) begin
                out_y_reg <= axis_val;
            end else begin
                out_x_reg <= axis_val;
            end
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

endmodule

`default_nettype wire

// ----- design/gsc_datapath.sv -----
// ----------------------------------------------------------------------------
// gsc_datapath: datapath of the gamepad sample conditioner
// Dead zone registers, button edge masks, trigger scaling, two stick lanes
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_datapath
    import gsc_pkg::*;
#(
    parameter int BUTTON_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DZ_W-1:0]        cfg_wdata,
    input  wire gsc_in_t                s_data,
    input  wire gsc_cmd_t               cmd,
    output gsc_out_t                    m_data
);

    localparam int KEEP_BITS = (BUTTON_BITS < BTN_W) ? BUTTON_BITS : BTN_W;

    logic [DZ_W-1:0]      left_dz_reg, right_dz_reg;
    logic [KEEP_BITS-1:0] prev_reg;
    logic [BTN_W-1:0]     pressed_reg, released_reg, held_reg;
    logic [TRIG_W-1:0]    ltrig_reg, rtrig_reg;
    gsc_out_t             out_reg;

    logic [BTN_W-1:0]         cur, prev;
    logic signed [AXIS_W-1:0] lx, ly, rx, ry;

    // dead zone registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dz_reg  <= LEFT_DZ_RESET;
            right_dz_reg <= RIGHT_DZ_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LEFT_DZ:  left_dz_reg  <= cfg_wdata;
                CFG_RIGHT_DZ: right_dz_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // button history
    assign cur  = BTN_W'(s_data.buttons[KEEP_BITS-1:0]);
    assign prev = BTN_W'(prev_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (cmd.capture) begin
            prev_reg <= cur[KEEP_BITS-1:0];
        end
    end

    // edge masks and triggers of the sample in work
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pressed_reg  <= cur & ~prev;
            released_reg <= ~cur & prev;
            held_reg     <= cur & prev;
            ltrig_reg    <= s_data.left_trigger;
            rtrig_reg    <= s_data.right_trigger;
        end
    end

    // stick lanes
    gsc_stick u_left (
        .aclk     (aclk),
        .cmd      (cmd),
        .raw_x    (s_data.left_x),
        .raw_y    (s_data.left_y),
        .deadzone (left_dz_reg),
        .out_x    (lx),
        .out_y    (ly)
    );

    gsc_stick u_right (
        .aclk     (aclk),
        .cmd      (cmd),
        .raw_x    (s_data.right_x),
        .raw_y    (s_data.right_y),
        .deadzone (right_dz_reg),
        .out_x    (rx),
        .out_y    (ry)
    );

    // result register, trigger times 257 is the byte repeated
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.pressed_mask        <= pressed_reg;
            out_reg.released_mask       <= released_reg;
            out_reg.held_mask           <= held_reg;
            out_reg.left_out_x          <= lx;
            out_reg.left_out_y          <= ly;
            out_reg.right_out_x         <= rx;
            out_reg.right_out_y         <= ry;
            out_reg.left_trigger_level  <= {ltrig_reg, ltrig_reg};
            out_reg.right_trigger_level <= {rtrig_reg, rtrig_reg};
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- design/gsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gsc_ctrl: controller of the gamepad sample conditioner
// Sequences square, root, prepare and the two axis divides, and owns the
// input ready and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_ctrl
    import gsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic poll_ok,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output gsc_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SQUARE    = 9'b000000010,
        ST_ROOT_INIT = 9'b000000100,
        ST_ROOT_STEP = 9'b000001000,
        ST_PREP      = 9'b000010000,
        ST_DIV_INIT  = 9'b000100000,
        ST_DIV_STEP  = 9'b001000000,
        ST_DIV_DONE  = 9'b010000000,
        ST_OUTPUT    = 9'b100000000
    } gsc_state_t;

    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);

    gsc_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              axis_reg, axis_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis_y = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && poll_ok) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT: begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT_STEP;
            end
            ST_ROOT_STEP: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                axis_next  = 1'b0;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                cmd.div_store = 1'b1;
                if (axis_reg) begin
                    state_next = ST_OUTPUT;
                end else begin
                    axis_next  = 1'b1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared on transfer
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- design/gamepad_sample_conditioner.sv -----
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner: gamepad poll sample conditioner
// Button edge masks, radial dead zone on both sticks, trigger scaling.
//
//   channel   ports                              direction
//   input     s_valid / s_ready / s_data         one poll sample in
//   result    m_valid / m_ready / m_data         one conditioned sample out
//   config    cfg_we / cfg_index / cfg_wdata     dead zone register writes
//
// a good poll runs square, root init, the 16-step root and prepare, then per
// axis a divide init, a 16-step divide and a store, then the output load,
// before the next ready; both stick lanes run these at once
// a failed poll is dropped in its transfer cycle and changes nothing
// the result register frees the input side; work stalls only in the last
// cycle if the previous result has not been taken
// reset restores the dead zones and clears the button history, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_sample_conditioner
    import gsc_pkg::*;
#(
    parameter int BUTTON_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DZ_W-1:0]        cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire gsc_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output gsc_out_t                    m_data
);

    gsc_cmd_t cmd;

    // sequencer
    gsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .poll_ok (s_data.poll_ok),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // arithmetic and state
    gsc_datapath #(
        .BUTTON_BITS (BUTTON_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
